// ===== rtl/core/ccd_pkg.sv =====
`default_nettype none

package ccd_pkg;

    localparam int NUM_DENOMS         = 8;
    localparam int DEN_W              = 3;
    localparam int CENTS_W            = 20;
    localparam int PIECE_W            = 8;
    localparam int OP_W               = 2;
    localparam int CHANGE_W           = 11;
    localparam int VALUE_W            = 11;
    localparam int VALUE_SUM_W        = 12;
    localparam int REFILL_W           = 6;
    localparam int RECIP_W            = 17;
    localparam int RECIP_SHIFT        = 16;
    localparam int COUNT_BITS_DEFAULT = 8;
    localparam int S_TDATA_W          = 24;
    localparam int S_PAD_W            = S_TDATA_W - CENTS_W - DEN_W;
    localparam int M_TDATA_W          = 40;
    localparam int M_PAD_W            = M_TDATA_W - DEN_W - PIECE_W - CENTS_W - 2;
    localparam int REFILL_TOTAL       = 20000;

    localparam logic [CENTS_W-1:0] THRESH_RESET = 20'd5000;

    localparam logic [OP_W-1:0] OP_REFILL = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_DISPENSE = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [DEN_W-1:0]     den;
        logic [PIECE_W-1:0]   pieces;
        logic [CENTS_W-1:0]   cents;
        logic                 low;
        logic                 short_chg;
        logic                 last;
    } result_t;

    function automatic logic [VALUE_W-1:0] denom_value(input logic [DEN_W-1:0] idx);
        logic [VALUE_W-1:0] v;
        unique case (idx)
            3'd0: v = 11'd2000;
            3'd1: v = 11'd1000;
            3'd2: v = 11'd500;
            3'd3: v = 11'd100;
            3'd4: v = 11'd25;
            3'd5: v = 11'd10;
            3'd6: v = 11'd5;
            default: v = 11'd1;
        endcase
        return v;
    endfunction

    // floor(2^16 / value)
    function automatic logic [RECIP_W-1:0] denom_recip(input logic [DEN_W-1:0] idx);
        logic [RECIP_W-1:0] r;
        unique case (idx)
            3'd0: r = 17'd32;
            3'd1: r = 17'd65;
            3'd2: r = 17'd131;
            3'd3: r = 17'd655;
            3'd4: r = 17'd2621;
            3'd5: r = 17'd6553;
            3'd6: r = 17'd13107;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    function automatic logic [REFILL_W-1:0] refill_count(input logic [DEN_W-1:0] idx);
        logic [REFILL_W-1:0] c;
        unique case (idx)
            3'd0: c = 6'd4;
            3'd1: c = 6'd5;
            3'd2: c = 6'd6;
            3'd3: c = 6'd20;
            3'd4: c = 6'd54;
            3'd5: c = 6'd50;
            3'd6: c = 6'd20;
            default: c = 6'd50;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cash_change_dispenser_unit.sv =====
`default_nettype none

// Cash payment controller with eight denominations ($20, $10, $5, $1, 25c, 10c, 5c, 1c).
// Each input item (s_tuser = opcode) yields one status item, or for a completed payment
// one dispense item per denomination handed back followed by the status item (tlast).
// Piece counts live in an eight-entry count store with one write and one registered read
// port; counts read as zero until the first refill. Set-due with a nonzero amount,
// a partial insert and ignored items go straight to the status item, refill after it has
// written all eight entries. A payout walks all eight entries, each through read, divide
// and clamp, and write back (a write back that hands out pieces waits for the output
// register). The next item is taken once the status item is in the output register.
module cash_change_dispenser_unit #(
    parameter int COUNT_BITS = ccd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ccd_pkg::S_TDATA_W-1:0]  s_tdata,   // amount_cents, denomination
    input  logic [ccd_pkg::OP_W-1:0]       s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // paid_denomination, piece_count, owed_or_short_cents, low_reserve, short_change
    output logic [ccd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser,   // kind
    output logic                           m_tlast,
    input  logic                           cfg_wen,
    input  logic [ccd_pkg::CENTS_W-1:0]    cfg_wdata
);

    localparam int DEN_W    = ccd_pkg::DEN_W;
    localparam int CENTS_W  = ccd_pkg::CENTS_W;
    localparam int CHANGE_W = ccd_pkg::CHANGE_W;
    localparam int VALUE_W  = ccd_pkg::VALUE_W;
    localparam int PIECE_W  = ccd_pkg::PIECE_W;
    localparam int TOTAL_W  = COUNT_BITS + ccd_pkg::VALUE_SUM_W;
    localparam int TCMP_W   = (TOTAL_W > CENTS_W) ? TOTAL_W : CENTS_W;
    localparam int QCMP_W   = (CHANGE_W > COUNT_BITS) ? CHANGE_W : COUNT_BITS;
    localparam int QPROD_W  = CHANGE_W + ccd_pkg::RECIP_W;
    localparam int QD_W     = CHANGE_W + VALUE_W;
    localparam int REM_W    = CHANGE_W + 1;
    localparam int NPROD_W  = COUNT_BITS + VALUE_W;
    localparam int NEXT_W   = COUNT_BITS + PIECE_W;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_FILL = 3'd1;
    localparam logic [ST_W-1:0] ST_STAT = 3'd2;
    localparam logic [ST_W-1:0] ST_RD   = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV  = 3'd4;
    localparam logic [ST_W-1:0] ST_UPD  = 3'd5;
    localparam logic [ST_W-1:0] ST_FIN  = 3'd6;

    localparam logic [DEN_W-1:0] LAST_IDX = DEN_W'(ccd_pkg::NUM_DENOMS - 1);

    logic [ST_W-1:0]                state_reg, state_next;
    logic [DEN_W-1:0]               idx_reg, idx_next;
    logic [ccd_pkg::NUM_DENOMS-1:0] valid_reg, valid_next;
    logic [CENTS_W-1:0]             rem_reg, rem_next;
    logic                           status_low_reg, status_low_next;
    logic [CENTS_W-1:0]             thresh_reg;
    logic [CHANGE_W-1:0]            change_reg, change_next;
    logic [TOTAL_W-1:0]             total_reg, total_next;
    logic [CHANGE_W-1:0]            qraw_reg, qraw_next;
    logic [COUNT_BITS-1:0]          n_reg, n_next;
    logic [COUNT_BITS-1:0]          cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    ccd_pkg::result_t               out_reg, out_next;

    logic                  ram_we;
    logic [DEN_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] ram_rdata;

    logic [ccd_pkg::OP_W-1:0] in_op;
    logic [CENTS_W-1:0]       in_amount;
    logic [DEN_W-1:0]         in_den;
    logic [VALUE_W-1:0]       in_value;
    logic [CHANGE_W-1:0]      in_change;

    logic [VALUE_W-1:0]    cur_value;
    logic [QPROD_W-1:0]    qprod;
    logic [QD_W-1:0]       qd;
    logic [REM_W-1:0]      div_rem;
    logic [CHANGE_W-1:0]   quot;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [COUNT_BITS-1:0] cnt_left;
    logic [NPROD_W-1:0]    nd;
    logic [CHANGE_W-1:0]   change_after;
    logic [TOTAL_W-1:0]    left_val;
    logic [NEXT_W-1:0]     n_ext;
    logic                  out_free;
    logic                  accept;

    ccd_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ccd_pkg::NUM_DENOMS)
    ) u_count_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign in_op     = s_tuser;
    assign in_amount = s_tdata[CENTS_W-1:0];
    assign in_den    = s_tdata[CENTS_W +: DEN_W];
    assign in_value  = ccd_pkg::denom_value(in_den);
    assign in_change = in_value - rem_reg[CHANGE_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // divide change by the current denomination: reciprocal estimate, then one correction
    assign cur_value = ccd_pkg::denom_value(idx_reg);
    assign qprod     = QPROD_W'(change_reg) * QPROD_W'(ccd_pkg::denom_recip(idx_reg));
    assign qraw_next = qprod[ccd_pkg::RECIP_SHIFT +: CHANGE_W];
    assign qd        = QD_W'(qraw_reg) * QD_W'(cur_value);
    assign div_rem   = REM_W'(change_reg) - qd[REM_W-1:0];
    assign quot      = (div_rem >= REM_W'(cur_value)) ? qraw_reg + 1'b1 : qraw_reg;
    assign cnt_rd    = valid_reg[idx_reg] ? ram_rdata : '0;
    assign n_next    = (QCMP_W'(quot) < QCMP_W'(cnt_rd)) ? COUNT_BITS'(quot) : cnt_rd;
    assign cnt_next  = cnt_rd;

    assign cnt_left     = cnt_reg - n_reg;
    assign nd           = NPROD_W'(n_reg) * NPROD_W'(cur_value);
    assign change_after = change_reg - nd[CHANGE_W-1:0];
    assign left_val     = TOTAL_W'(cnt_left) * TOTAL_W'(cur_value);
    assign n_ext        = NEXT_W'(n_reg);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        rem_next        = rem_reg;
        status_low_next = status_low_reg;
        change_next     = change_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = cnt_left;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next   = '0;
                    total_next = '0;
                    unique case (in_op)
                        ccd_pkg::OP_REFILL: begin
                            state_next = ST_FILL;
                        end
                        ccd_pkg::OP_START: begin
                            rem_next = in_amount;
                            if (in_amount == '0) begin
                                change_next = '0;
                                state_next  = ST_RD;
                            end else begin
                                state_next = ST_STAT;
                            end
                        end
                        ccd_pkg::OP_INSERT: begin
                            if (rem_reg == '0) begin
                                state_next = ST_STAT;
                            end else if (rem_reg > CENTS_W'(in_value)) begin
                                rem_next   = rem_reg - CENTS_W'(in_value);
                                state_next = ST_STAT;
                            end else begin
                                change_next = in_change;
                                rem_next    = '0;
                                state_next  = ST_RD;
                            end
                        end
                        default: begin
                            state_next = ST_STAT;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                ram_we              = 1'b1;
                ram_wdata           = COUNT_BITS'(ccd_pkg::refill_count(idx_reg));
                valid_next[idx_reg] = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next        = '0;
                    status_low_next = TCMP_W'(ccd_pkg::REFILL_TOTAL) < TCMP_W'(thresh_reg);
                    state_next      = ST_STAT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    out_valid_next     = 1'b1;
                    out_next.kind      = ccd_pkg::KIND_STATUS;
                    out_next.den       = '0;
                    out_next.pieces    = '0;
                    out_next.cents     = rem_reg;
                    out_next.low       = status_low_reg;
                    out_next.short_chg = 1'b0;
                    out_next.last      = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            ST_RD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (n_reg == '0 || out_free) begin
                    total_next  = total_reg + left_val;
                    change_next = change_after;
                    if (n_reg != '0) begin
                        ram_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        out_valid_next      = 1'b1;
                        out_next.kind       = ccd_pkg::KIND_DISPENSE;
                        out_next.den        = idx_reg;
                        out_next.pieces     = n_ext[PIECE_W-1:0];
                        out_next.cents      = CENTS_W'(change_after);
                        out_next.low        = 1'b0;
                        out_next.short_chg  = 1'b0;
                        out_next.last       = 1'b0;
                    end
                    if (idx_reg == LAST_IDX) begin
                        idx_next   = '0;
                        state_next = ST_FIN;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next.kind   = ccd_pkg::KIND_STATUS;
                    out_next.den    = '0;
                    out_next.pieces = '0;
                    out_next.cents  = CENTS_W'(change_reg);
                    out_next.last   = 1'b1;
                    if (change_reg != '0) begin
                        status_low_next    = 1'b1;
                        out_next.low       = 1'b1;
                        out_next.short_chg = 1'b1;
                    end else begin
                        status_low_next    = TCMP_W'(total_reg) < TCMP_W'(thresh_reg);
                        out_next.low       = status_low_next;
                        out_next.short_chg = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            rem_reg        <= '0;
            status_low_reg <= 1'b1;
            thresh_reg     <= ccd_pkg::THRESH_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            rem_reg        <= rem_next;
            status_low_reg <= status_low_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wen) begin
                thresh_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        change_reg <= change_next;
        total_reg  <= total_next;
        out_reg    <= out_next;
        if (state_reg == ST_RD) begin
            qraw_reg <= qraw_next;
        end
        if (state_reg == ST_DIV) begin
            n_reg   <= n_next;
            cnt_reg <= cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {{ccd_pkg::M_PAD_W{1'b0}}, out_reg.short_chg, out_reg.low,
                       out_reg.cents, out_reg.pieces, out_reg.den};

endmodule

`default_nettype wire

// ===== rtl/core/ccd_ram.sv =====
`default_nettype none

module ccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccd_checker.sv =====
`default_nettype none

module ccd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ccd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    // one item at a time: input closes right after an item is taken
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after accepting an item");

    // only the status item ends the run of results
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == ccd_pkg::KIND_STATUS) == m_tlast))
        else $error("tlast does not match status kind");

    // short change is reported only on status and always with low reserve
    a_short_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31] && (m_tuser == ccd_pkg::KIND_STATUS))
        else $error("short change without low reserve on status");

    // a dispense item hands back at least one piece
    a_dispense_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ccd_pkg::KIND_DISPENSE) |-> (m_tdata[10:3] != '0))
        else $error("dispense item with zero pieces");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output item changed");

endmodule

bind cash_change_dispenser_unit ccd_checker u_ccd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
